FILE: src/dctp_pkg.sv
`timescale 1ns / 1ps
// shared constants, command codes, control structs and tree helpers for the prune block
package dctp_pkg;

    localparam int NODES     = 15;
    localparam int LAYERS    = 4;
    localparam int PAIRS     = 3;
    localparam int LAST_NODE = 14;
    localparam int DEF_SLOTS = 8;

    localparam int CMD_W   = 2;
    localparam int NODE_W  = 4;
    localparam int SLOT_W  = 3;
    localparam int IDENT_W = 16;
    localparam int LAYER_W = 2;

    localparam logic [CMD_W-1:0] CMD_RESET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRUNE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic walk;
        logic finish;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic prune_go;
        logic walk_last;
        logic out_free;
    } t_ctl_sts;

    function automatic logic [LAYER_W-1:0] layer_of(input logic [NODE_W-1:0] n);
        logic [NODE_W:0] p;
        logic [LAYER_W-1:0] l;
        p = {1'b0, n} + (NODE_W+1)'(1);
        priority if (p >= (NODE_W+1)'(8)) l = 2'd3;
        else if (p >= (NODE_W+1)'(4))     l = 2'd2;
        else if (p >= (NODE_W+1)'(2))     l = 2'd1;
        else                              l = 2'd0;
        return l;
    endfunction

    // subtree of m plus every ancestor of m
    function automatic logic [NODES-1:0] clear_mask(input logic [NODE_W-1:0] m);
        logic [NODES-1:0] mask;
        logic [NODE_W:0] mp;
        logic [NODE_W:0] ip;
        mask = '0;
        mp = {1'b0, m} + (NODE_W+1)'(1);
        for (int i = 0; i < NODES; i++) begin
            ip = (NODE_W+1)'(i + 1);
            for (int k = 0; k < LAYERS; k++) begin
                if ((ip >> k) == mp || (mp >> k) == ip) begin
                    mask[i] = 1'b1;
                end
            end
        end
        return mask;
    endfunction

endpackage

FILE: src/dctp_ram.sv
`timescale 1ns / 1ps
// generic ram, one write port and two registered read ports
module dctp_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: src/dctp_ctrl.sv
`timescale 1ns / 1ps
// command sequencer for reset, load and prune
module dctp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dctp_pkg::t_ctl_sts i_sts,
    output dctp_pkg::t_ctl_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_EXEC;
            S_EXEC:  n_state = i_sts.prune_go ? S_WALK : S_FIN;
            S_WALK:  if (i_sts.walk_last) n_state = S_DRAIN;
            S_DRAIN: n_state = S_FIN;
            S_FIN:   if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_cmd.capture  = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.walk     = (r_state == S_WALK);
    assign o_cmd.finish   = (r_state == S_FIN) && i_sts.out_free;

    // the walk always ends before the result is built
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && i_sts.walk_last |=> (r_state == S_DRAIN) ##1 (r_state == S_FIN))
        else $error("walk did not drain into finish");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.exec)
        else $error("captured command not executed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && !i_sts.prune_go |=> (r_state == S_FIN))
        else $error("non-prune command entered the walk");

endmodule

FILE: src/dctp_datapath.sv
`timescale 1ns / 1ps
// identifier store, slot compare walk, cleared flags and output register
module dctp_datapath #(
    parameter int SLOTS = dctp_pkg::DEF_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dctp_pkg::t_ctl_cmd            i_cmd,
    output dctp_pkg::t_ctl_sts            o_sts,
    input  logic [dctp_pkg::CMD_W-1:0]    i_cmd_code,
    input  logic [dctp_pkg::NODE_W-1:0]   i_node,
    input  logic [dctp_pkg::SLOT_W-1:0]   i_slot,
    input  logic [dctp_pkg::IDENT_W-1:0]  i_ident,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_matched,
    output logic [dctp_pkg::NODE_W-1:0]   o_match_node,
    output logic [dctp_pkg::SLOT_W-1:0]   o_match_slot,
    output logic [dctp_pkg::IDENT_W-1:0]  o_match_ident,
    output logic [dctp_pkg::LAYER_W-1:0]  o_match_layer,
    output logic [dctp_pkg::NODES-1:0]    o_cleared_mask
);

    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH  = dctp_pkg::NODES << SW;
    localparam int ADDR_W = dctp_pkg::NODE_W + SW;

    // captured command
    logic [dctp_pkg::CMD_W-1:0]   r_cmd;
    logic [dctp_pkg::NODE_W-1:0]  r_node;
    logic [dctp_pkg::SLOT_W-1:0]  r_slot;
    logic [dctp_pkg::IDENT_W-1:0] r_ident;

    // walk
    logic [dctp_pkg::NODE_W-1:0]  r_child;
    logic [SW-1:0]                r_scnt;
    logic [dctp_pkg::NODE_W-1:0]  w_parent;
    logic                         w_slot_last;
    logic                         r_rd_vld;
    logic [dctp_pkg::NODE_W-1:0]  r_tag_p;
    logic [SW-1:0]                r_tag_s;
    logic                         r_va;
    logic                         r_vb;

    // store
    logic [DEPTH-1:0]             r_valid;
    logic                         w_we;
    logic [ADDR_W-1:0]            w_waddr;
    logic [ADDR_W-1:0]            w_raddr_a;
    logic [ADDR_W-1:0]            w_raddr_b;
    logic [dctp_pkg::IDENT_W-1:0] w_rdata_a;
    logic [dctp_pkg::IDENT_W-1:0] w_rdata_b;
    logic [dctp_pkg::IDENT_W-1:0] w_id_a;
    logic [dctp_pkg::IDENT_W-1:0] w_id_b;
    logic                         w_hit;

    // running best match
    logic                         r_matched;
    logic [dctp_pkg::NODE_W-1:0]  r_mnode;
    logic [SW-1:0]                r_mslot;
    logic [dctp_pkg::IDENT_W-1:0] r_mident;

    logic [dctp_pkg::NODES-1:0]   r_flags;
    logic [dctp_pkg::NODES-1:0]   n_flags;

    // output register
    logic                          r_o_valid;
    logic                          r_o_matched;
    logic [dctp_pkg::NODE_W-1:0]   r_o_node;
    logic [dctp_pkg::SLOT_W-1:0]   r_o_slot;
    logic [dctp_pkg::IDENT_W-1:0]  r_o_ident;
    logic [dctp_pkg::LAYER_W-1:0]  r_o_layer;
    logic [dctp_pkg::NODES-1:0]    r_o_mask;

    logic w_node_ok;
    logic w_slot_ok;

    assign w_node_ok = (r_node <= dctp_pkg::NODE_W'(dctp_pkg::LAST_NODE));
    assign w_slot_ok = ({3'b000, r_slot} < 6'(SLOTS));

    assign w_we    = i_cmd.exec && (r_cmd == dctp_pkg::CMD_LOAD) && w_node_ok && w_slot_ok;
    assign w_waddr = {r_node, SW'(r_slot)};

    assign w_parent    = (r_child - dctp_pkg::NODE_W'(1)) >> 1;
    assign w_slot_last = (r_scnt == SW'(SLOTS - 1));
    assign w_raddr_a   = {r_child, r_scnt};
    assign w_raddr_b   = {w_parent, r_scnt};

    dctp_ram #(
        .WIDTH (dctp_pkg::IDENT_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (r_ident),
        .i_raddr_a(w_raddr_a),
        .i_raddr_b(w_raddr_b),
        .o_rdata_a(w_rdata_a),
        .o_rdata_b(w_rdata_b)
    );

    // entries never written since the last reset read as empty
    assign w_id_a = r_va ? w_rdata_a : '0;
    assign w_id_b = r_vb ? w_rdata_b : '0;
    assign w_hit  = r_rd_vld && (w_id_a != '0) && (w_id_a == w_id_b);

    assign o_sts.prune_go  = (r_cmd == dctp_pkg::CMD_PRUNE) && w_node_ok &&
                             (r_node != '0);
    assign o_sts.walk_last = w_slot_last && (w_parent == '0);
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    assign n_flags = r_flags | (r_matched ? dctp_pkg::clear_mask(r_mnode) : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_cmd_code;
            r_node  <= i_node;
            r_slot  <= i_slot;
            r_ident <= i_ident;
        end
        if (i_cmd.exec) begin
            r_child <= r_node;
            r_scnt  <= '0;
        end else if (i_cmd.walk) begin
            if (w_slot_last) begin
                r_scnt  <= '0;
                r_child <= w_parent;
            end else begin
                r_scnt <= r_scnt + SW'(1);
            end
        end
        r_tag_p <= w_parent;
        r_tag_s <= r_scnt;
        r_va    <= r_valid[w_raddr_a];
        r_vb    <= r_valid[w_raddr_b];
        if (i_cmd.capture) begin
            r_mnode  <= '0;
            r_mslot  <= '0;
            r_mident <= '0;
        end else if (w_hit) begin
            // later hits are nearer the root or a higher slot
            r_mnode  <= r_tag_p;
            r_mslot  <= r_tag_s;
            r_mident <= w_id_b;
        end
        if (i_cmd.finish) begin
            r_o_matched <= r_matched;
            r_o_node    <= r_mnode;
            r_o_slot    <= dctp_pkg::SLOT_W'(r_mslot);
            r_o_ident   <= r_mident;
            r_o_layer   <= dctp_pkg::layer_of(r_mnode);
            r_o_mask    <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_flags   <= '0;
            r_rd_vld  <= 1'b0;
            r_matched <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.walk;
            if (i_cmd.exec && (r_cmd == dctp_pkg::CMD_RESET)) begin
                r_valid <= '0;
                r_flags <= '0;
            end else begin
                if (w_we) begin
                    r_valid[w_waddr] <= 1'b1;
                end
                if (i_cmd.finish) begin
                    r_flags <= n_flags;
                end
            end
            if (i_cmd.capture) begin
                r_matched <= 1'b0;
            end else if (w_hit) begin
                r_matched <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_matched      = r_o_matched;
    assign o_match_node   = r_o_node;
    assign o_match_slot   = r_o_slot;
    assign o_match_ident  = r_o_ident;
    assign o_match_layer  = r_o_layer;
    assign o_cleared_mask = r_o_mask;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_matched |-> (r_o_node == '0) && (r_o_slot == '0) &&
        (r_o_ident == '0) && (r_o_layer == '0))
        else $error("match fields set without a match");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_matched |-> r_o_mask[r_o_node] && r_o_mask[0] && (r_o_ident != '0))
        else $error("matched node or root not marked cleared");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.exec && (r_cmd == dctp_pkg::CMD_RESET)) |=>
        ((r_flags & $past(r_flags)) == $past(r_flags)))
        else $error("cleared flag dropped without a reset command");

endmodule

FILE: src/dci_candidate_tree_prune.sv
`timescale 1ns / 1ps
// Commands: one at a time; reset, load, the unused command and a prune with no walk
// (root or spare node index) go straight to the result, a prune from layer L >= 1 walks
// every slot of each pair up to the root first, reading one slot pair per cycle from the
// dual-read identifier ram.
// Reset: synchronous active-low i_rst_n empties every slot (valid bits) and cleared flag,
// and drops a pending result on m_axis_tvalid.
module dci_candidate_tree_prune #(
    parameter int SLOTS = dctp_pkg::DEF_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // cmd[1:0], node[5:2], slot[8:6], ident[24:9], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // matched[0], match_node[4:1], match_slot[7:5],
                                       // match_ident[23:8], match_layer[25:24],
                                       // cleared_mask[40:26], zero
);

    dctp_pkg::t_ctl_cmd w_cmd;
    dctp_pkg::t_ctl_sts w_sts;

    logic                          w_matched;
    logic [dctp_pkg::NODE_W-1:0]   w_match_node;
    logic [dctp_pkg::SLOT_W-1:0]   w_match_slot;
    logic [dctp_pkg::IDENT_W-1:0]  w_match_ident;
    logic [dctp_pkg::LAYER_W-1:0]  w_match_layer;
    logic [dctp_pkg::NODES-1:0]    w_cleared_mask;

    dctp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    dctp_datapath #(
        .SLOTS(SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cmd_code    (s_axis_tdata[1:0]),
        .i_node        (s_axis_tdata[5:2]),
        .i_slot        (s_axis_tdata[8:6]),
        .i_ident       (s_axis_tdata[24:9]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_matched     (w_matched),
        .o_match_node  (w_match_node),
        .o_match_slot  (w_match_slot),
        .o_match_ident (w_match_ident),
        .o_match_layer (w_match_layer),
        .o_cleared_mask(w_cleared_mask)
    );

    assign m_axis_tdata = {7'd0, w_cleared_mask, w_match_layer, w_match_ident,
                           w_match_slot, w_match_node, w_matched};

endmodule

FILE: tb/tb_dci_candidate_tree_prune.sv
`timescale 1ns / 1ps
// self-checking testbench for the prune block: directed command table, then random sequences
module tb_dci_candidate_tree_prune;

    localparam int TREE_SLOTS   = dctp_pkg::DEF_SLOTS;
    localparam logic [dctp_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int ITEM_TARGET  = 1550;
    localparam int CALM_TAIL    = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS   = 200;

    // packed so that it lines up with m_axis_tdata[40:0]
    typedef struct packed {
        logic [dctp_pkg::NODES-1:0]   cleared;
        logic [dctp_pkg::LAYER_W-1:0] layer;
        logic [dctp_pkg::IDENT_W-1:0] ident;
        logic [dctp_pkg::SLOT_W-1:0]  slot;
        logic [dctp_pkg::NODE_W-1:0]  node;
        logic                         matched;
    } t_prune_verdict;

    typedef struct {
        logic [dctp_pkg::CMD_W-1:0]   cmd;
        logic [dctp_pkg::NODE_W-1:0]  node;
        logic [dctp_pkg::SLOT_W-1:0]  slot;
        logic [dctp_pkg::IDENT_W-1:0] ident;
        bit                           typed;
        t_prune_verdict               want;
    } t_cmd_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // cmd[1:0], node[5:2], slot[8:6], ident[24:9], zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // matched[0], match_node[4:1], match_slot[7:5],
                                 // match_ident[23:8], match_layer[25:24],
                                 // cleared_mask[40:26], zero

    // shadow copy of the tree
    logic [dctp_pkg::IDENT_W-1:0] tree_ident [dctp_pkg::NODES][TREE_SLOTS];
    logic [dctp_pkg::NODES-1:0]   tree_cleared;

    t_prune_verdict pending_verdicts [$];
    t_cmd_row       cmd_table [$];
    bit             drive_typed;
    t_prune_verdict drive_want;
    bit             src_idle_en;
    bit             sink_idle_en;
    int             sent_count;
    int             fail_count;
    int             quiet_cycles;

    dci_candidate_tree_prune uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int tree_depth(input int n);
        int d;
        d = 0;
        while (n > 0) begin
            n = (n - 1) / 2;
            d++;
        end
        return d;
    endfunction

    // applies one command to the shadow tree and returns the result it should give
    function automatic t_prune_verdict apply_tree_cmd(
        input logic [dctp_pkg::CMD_W-1:0]   cmd,
        input logic [dctp_pkg::NODE_W-1:0]  node,
        input logic [dctp_pkg::SLOT_W-1:0]  slot,
        input logic [dctp_pkg::IDENT_W-1:0] ident);
        t_prune_verdict v;
        int child;
        int parent;
        int hit;
        int j;
        v = '0;
        case (cmd)
            dctp_pkg::CMD_RESET: begin
                for (int n = 0; n < dctp_pkg::NODES; n++)
                    for (int s = 0; s < TREE_SLOTS; s++)
                        tree_ident[n][s] = '0;
                tree_cleared = '0;
            end
            dctp_pkg::CMD_LOAD: begin
                if (node <= dctp_pkg::LAST_NODE && slot < TREE_SLOTS)
                    tree_ident[node][slot] = ident;
            end
            dctp_pkg::CMD_PRUNE: begin
                if (node <= dctp_pkg::LAST_NODE) begin
                    child = int'(node);
                    // each pair nearer the root overrides the one below it
                    while (child > 0) begin
                        parent = (child - 1) / 2;
                        hit = -1;
                        for (int s = 0; s < TREE_SLOTS; s++)
                            if (tree_ident[child][s] != '0 &&
                                tree_ident[child][s] == tree_ident[parent][s])
                                hit = s;
                        if (hit >= 0) begin
                            v.matched = 1'b1;
                            v.node    = dctp_pkg::NODE_W'(parent);
                            v.slot    = dctp_pkg::SLOT_W'(hit);
                            v.ident   = tree_ident[parent][hit];
                        end
                        child = parent;
                    end
                    if (v.matched) begin
                        v.layer = dctp_pkg::LAYER_W'(tree_depth(int'(v.node)));
                        for (int i = 0; i < dctp_pkg::NODES; i++) begin
                            j = i;
                            while (j > int'(v.node)) j = (j - 1) / 2;
                            if (j == int'(v.node)) tree_cleared[i] = 1'b1;
                        end
                        j = int'(v.node);
                        tree_cleared[j] = 1'b1;
                        while (j > 0) begin
                            j = (j - 1) / 2;
                            tree_cleared[j] = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        v.cleared = tree_cleared;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] want,
                                   input logic [47:0] got);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $time);
    endtask

    always @(posedge i_clk) begin : check_proc
        t_prune_verdict want;
        t_prune_verdict got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = apply_tree_cmd(s_axis_tdata[1:0], s_axis_tdata[5:2],
                                      s_axis_tdata[8:6], s_axis_tdata[24:9]);
                if (drive_typed) want = drive_want;
                pending_verdicts.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[40:0];
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("unexpected transfer", '0, 48'(got));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.matched !== want.matched)
                        report_mismatch("matched", 48'(want.matched), 48'(got.matched));
                    if (got.node !== want.node)
                        report_mismatch("match_node", 48'(want.node), 48'(got.node));
                    if (got.slot !== want.slot)
                        report_mismatch("match_slot", 48'(want.slot), 48'(got.slot));
                    if (got.ident !== want.ident)
                        report_mismatch("match_ident", 48'(want.ident), 48'(got.ident));
                    if (got.layer !== want.layer)
                        report_mismatch("match_layer", 48'(want.layer), 48'(got.layer));
                    if (got.cleared !== want.cleared)
                        report_mismatch("cleared_mask", 48'(want.cleared),
                                        48'(got.cleared));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_dci_candidate_tree_prune: FAIL");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin : sink_proc
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_cmd(input logic [dctp_pkg::CMD_W-1:0]   cmd,
                            input logic [dctp_pkg::NODE_W-1:0]  node,
                            input logic [dctp_pkg::SLOT_W-1:0]  slot,
                            input logic [dctp_pkg::IDENT_W-1:0] ident,
                            input bit typed, input t_prune_verdict want);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, ident, slot, node, cmd};
        drive_typed   <= typed;
        drive_want    <= want;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_plain(input logic [dctp_pkg::CMD_W-1:0]   cmd,
                              input logic [dctp_pkg::NODE_W-1:0]  node,
                              input logic [dctp_pkg::SLOT_W-1:0]  slot,
                              input logic [dctp_pkg::IDENT_W-1:0] ident);
        send_cmd(cmd, node, slot, ident, 1'b0, '0);
    endtask

    task automatic add_row(input logic [dctp_pkg::CMD_W-1:0]   cmd,
                           input logic [dctp_pkg::NODE_W-1:0]  node,
                           input logic [dctp_pkg::SLOT_W-1:0]  slot,
                           input logic [dctp_pkg::IDENT_W-1:0] ident,
                           input bit typed);
        t_cmd_row r;
        r.cmd   = cmd;
        r.node  = node;
        r.slot  = slot;
        r.ident = ident;
        r.typed = typed;
        r.want  = '0;   // every typed row expects an empty result on a clean tree
        cmd_table.push_back(r);
    endtask

    // loads mostly matching identifiers on one path to the root; usually prunes from its bottom
    task automatic random_sequence();
        logic [dctp_pkg::IDENT_W-1:0] pool [3];
        logic [dctp_pkg::IDENT_W-1:0] v;
        int start;
        int c;
        int p;
        int s;
        for (int i = 0; i < 3; i++)
            pool[i] = dctp_pkg::IDENT_W'($urandom_range(1, 16'hFFFF));
        if ($urandom_range(0, 5) == 0)
            send_plain(dctp_pkg::CMD_RESET, dctp_pkg::NODE_W'($urandom_range(0, 15)),
                       dctp_pkg::SLOT_W'($urandom), dctp_pkg::IDENT_W'($urandom));
        start = $urandom_range(1, dctp_pkg::LAST_NODE);
        repeat ($urandom_range(1, 3)) begin
            c = start;
            repeat ($urandom_range(0, tree_depth(start) - 1)) c = (c - 1) / 2;
            p = (c - 1) / 2;
            s = $urandom_range(0, TREE_SLOTS - 1);
            v = pool[$urandom_range(0, 2)];
            if ($urandom_range(0, 9) == 0) v = '0;
            send_plain(dctp_pkg::CMD_LOAD, dctp_pkg::NODE_W'(c), dctp_pkg::SLOT_W'(s), v);
            if ($urandom_range(0, 4) == 0) v = pool[$urandom_range(0, 2)];
            send_plain(dctp_pkg::CMD_LOAD, dctp_pkg::NODE_W'(p), dctp_pkg::SLOT_W'(s), v);
        end
        // noise: any command, any node including the spare index
        if ($urandom_range(0, 4) == 0)
            send_plain(dctp_pkg::CMD_W'($urandom_range(0, 3)),
                       dctp_pkg::NODE_W'($urandom_range(0, 15)),
                       dctp_pkg::SLOT_W'($urandom), dctp_pkg::IDENT_W'($urandom));
        if ($urandom_range(0, 9) == 0)
            send_plain(dctp_pkg::CMD_PRUNE, dctp_pkg::NODE_W'($urandom_range(0, 15)),
                       dctp_pkg::SLOT_W'($urandom), dctp_pkg::IDENT_W'($urandom));
        else
            send_plain(dctp_pkg::CMD_PRUNE, dctp_pkg::NODE_W'(start),
                       dctp_pkg::SLOT_W'($urandom), dctp_pkg::IDENT_W'($urandom));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        drive_typed   = 1'b0;
        drive_want    = '0;
        src_idle_en   = 1'b0;
        sink_idle_en  = 1'b0;
        sent_count    = 0;
        fail_count    = 0;
        quiet_cycles  = 0;
        void'(apply_tree_cmd(dctp_pkg::CMD_RESET, '0, '0, '0));

        //        cmd                  node   slot  ident     typed
        add_row(dctp_pkg::CMD_RESET, 4'd0,  3'd0, 16'h0000, 1'b1);
        add_row(CMD_SPARE,           4'd15, 3'd7, 16'hFFFF, 1'b1);  // unused command
        add_row(dctp_pkg::CMD_LOAD,  4'd0,  3'd7, 16'hFFFF, 1'b1);
        add_row(dctp_pkg::CMD_LOAD,  4'd1,  3'd7, 16'hFFFF, 1'b1);
        add_row(dctp_pkg::CMD_LOAD,  4'd3,  3'd0, 16'h0001, 1'b1);
        add_row(dctp_pkg::CMD_LOAD,  4'd7,  3'd0, 16'h0001, 1'b1);
        add_row(dctp_pkg::CMD_PRUNE, 4'd0,  3'd0, 16'h0000, 1'b1);  // root has no parent
        add_row(dctp_pkg::CMD_PRUNE, 4'd15, 3'd0, 16'h0000, 1'b1);  // node out of range
        add_row(dctp_pkg::CMD_LOAD,  4'd15, 3'd3, 16'h1234, 1'b1);  // ignored load
        add_row(dctp_pkg::CMD_PRUNE, 4'd14, 3'd0, 16'h0000, 1'b1);  // empty path
        add_row(dctp_pkg::CMD_PRUNE, 4'd7,  3'd0, 16'h0000, 1'b0);  // two matches, root wins
        add_row(dctp_pkg::CMD_PRUNE, 4'd7,  3'd0, 16'h0000, 1'b0);  // cleared flags do not block
        add_row(CMD_SPARE,           4'd0,  3'd0, 16'h0000, 1'b0);
        add_row(dctp_pkg::CMD_RESET, 4'd0,  3'd0, 16'h0000, 1'b1);
        add_row(dctp_pkg::CMD_LOAD,  4'd14, 3'd4, 16'hAAAA, 1'b1);
        add_row(dctp_pkg::CMD_LOAD,  4'd6,  3'd4, 16'hAAAA, 1'b1);
        add_row(dctp_pkg::CMD_LOAD,  4'd6,  3'd2, 16'h5555, 1'b1);
        add_row(dctp_pkg::CMD_LOAD,  4'd14, 3'd2, 16'h5555, 1'b1);
        add_row(dctp_pkg::CMD_PRUNE, 4'd14, 3'd0, 16'h0000, 1'b0);  // highest slot wins
        add_row(dctp_pkg::CMD_LOAD,  4'd14, 3'd4, 16'h0000, 1'b0);  // empty a slot again
        add_row(dctp_pkg::CMD_PRUNE, 4'd14, 3'd0, 16'h0000, 1'b0);
        add_row(dctp_pkg::CMD_LOAD,  4'd4,  3'd1, 16'h8000, 1'b0);
        add_row(dctp_pkg::CMD_LOAD,  4'd9,  3'd1, 16'h8000, 1'b0);
        add_row(dctp_pkg::CMD_PRUNE, 4'd9,  3'd0, 16'h0000, 1'b0);
        add_row(dctp_pkg::CMD_PRUNE, 4'd1,  3'd0, 16'h0000, 1'b0);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (cmd_table[i])
            send_cmd(cmd_table[i].cmd, cmd_table[i].node, cmd_table[i].slot,
                     cmd_table[i].ident, cmd_table[i].typed, cmd_table[i].want);

        while (sent_count < ITEM_TARGET) begin
            if (sent_count >= ITEM_TARGET - CALM_TAIL) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end else begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            random_sequence();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_dci_candidate_tree_prune: PASS");
        else
            $display("tb_dci_candidate_tree_prune: FAIL");
        $finish;
    end

endmodule

FILE: dci_candidate_tree_prune.f
src/dctp_pkg.sv
src/dctp_ram.sv
src/dctp_ctrl.sv
src/dctp_datapath.sv
src/dci_candidate_tree_prune.sv
tb/tb_dci_candidate_tree_prune.sv
